### src/cat_pkg.sv
// Shared types, codes and constants for the chunk address translator.
// No dependencies; cat_ctrl, cat_datapath and the top level import this package.
package cat_pkg;

    // Default sizes of the chunk table and of the per-chunk stripe list
    localparam int MAX_CHUNKS_DEF  = 64;
    localparam int MAX_STRIPES_DEF = 8;

    // Fixed field widths
    localparam int ADDR_W   = 64;
    localparam int FLAGS_W  = 16;
    localparam int STAT_W   = 3;
    localparam int REQ_W    = 2;
    localparam int CFG_W    = 64;
    localparam int PADDR_W  = 4;

    // Stream payload layout: input logical, length, flags, device, offset
    localparam int IN_DATA_W  = 4 * ADDR_W + FLAGS_W;   // 272, whole bytes
    localparam int OUT_DATA_W = 72;                     // status + phys, padded

    // RAID0, RAID10, RAID5, RAID6 profile bits
    localparam logic [FLAGS_W-1:0] STRIPED_MASK = 16'h01C8;

    // Register select values (the value of address bit 3 that selects the register)
    localparam int REG_IMAGE_BASE = 0;
    localparam int REG_DEVICE_ID  = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_HEADER = 2'd1,
        REQ_STRIPE = 2'd2,
        REQ_LOOKUP = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_NO_CHUNK   = 3'd1,
        STAT_STRIPED    = 3'd2,
        STAT_NO_DEV     = 3'd3,
        STAT_TABLE_FULL = 3'd4,
        STAT_TOO_MANY   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STRIPE,
        ST_DONE
    } state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic acc;       // input transfer this cycle
        logic scan;      // chunk table scan active
        logic strp;      // stripe scan active
        logic out_load;  // move result into output register
    } ctrl_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic is_lookup;      // incoming request is a lookup
        logic tbl_empty;      // no committed chunks
        logic ent_go_stripe;  // covering chunk found, stripe scan needed
        logic ent_done;       // chunk scan finished with a result
        logic str_done;       // stripe scan finished with a result
        logic out_free;       // output register can take a result
    } dp_stat_t;

endpackage

### src/cat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the chunk table and the stripe store.
module cat_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/cat_ctrl.sv
// Sequencing state machine of the chunk address translator.
// Depends on cat_pkg; drives commands to cat_datapath from its status.
module cat_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cat_pkg::dp_stat_t   stat,
    output cat_pkg::ctrl_cmd_t  cmd
);
    import cat_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.is_lookup && !stat.tbl_empty) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (stat.ent_go_stripe) begin
                    state_next = ST_STRIPE;
                end else if (stat.ent_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_STRIPE: begin
                if (stat.str_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        cmd.acc      = (state_reg == ST_IDLE) && s_tvalid;
        cmd.scan     = (state_reg == ST_SCAN);
        cmd.strp     = (state_reg == ST_STRIPE);
        cmd.out_load = (state_reg == ST_DONE) && stat.out_free;
    end

endmodule

### src/cat_datapath.sv
// Datapath: staging registers, chunk table and stripe store, scan
// counters, compare logic and the output register. Depends on cat_pkg
// and cat_ram; commanded by cat_ctrl.
module cat_datapath #(
    parameter int MAX_CHUNKS  = cat_pkg::MAX_CHUNKS_DEF,
    parameter int MAX_STRIPES = cat_pkg::MAX_STRIPES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cat_pkg::ctrl_cmd_t              cmd,
    output cat_pkg::dp_stat_t               stat,
    input  logic [cat_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [cat_pkg::REQ_W-1:0]       s_tuser,
    input  logic                            s_tlast,
    input  logic [cat_pkg::CFG_W-1:0]       image_base,
    input  logic [cat_pkg::CFG_W-1:0]       device_id,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [cat_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import cat_pkg::*;

    localparam int CW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNTW = $clog2(MAX_CHUNKS + 1);
    localparam int SCW  = $clog2(MAX_STRIPES + 1);
    localparam int SD   = MAX_CHUNKS * MAX_STRIPES;
    localparam int SAW  = (SD > 1) ? $clog2(SD) : 1;
    localparam int EW   = 2 * ADDR_W + 1 + SCW;

    // Input fields
    logic [ADDR_W-1:0]  in_logical;
    logic [ADDR_W-1:0]  in_length;
    logic [FLAGS_W-1:0] in_flags;
    logic [ADDR_W-1:0]  in_dev;
    logic [ADDR_W-1:0]  in_off;
    req_t               in_req;

    assign in_logical = s_tdata[ADDR_W-1:0];
    assign in_length  = s_tdata[2*ADDR_W-1:ADDR_W];
    assign in_flags   = s_tdata[2*ADDR_W+FLAGS_W-1:2*ADDR_W];
    assign in_dev     = s_tdata[3*ADDR_W+FLAGS_W-1:2*ADDR_W+FLAGS_W];
    assign in_off     = s_tdata[4*ADDR_W+FLAGS_W-1:3*ADDR_W+FLAGS_W];
    assign in_req     = req_t'(s_tuser);

    // Table and staging state
    logic [CNTW-1:0]   entry_count_reg;
    logic [ADDR_W-1:0] staged_start_reg;
    logic [ADDR_W-1:0] staged_size_reg;
    logic              staged_striped_reg;
    logic [SCW-1:0]    staged_stripes_reg;

    // Lookup scan state
    logic [ADDR_W-1:0] addr_reg;
    logic [CNTW-1:0]   scan_idx_reg;
    logic [CW-1:0]     chk_idx_reg;
    logic              rd_pend_reg;
    logic [SCW-1:0]    sidx_reg;
    logic [SCW-1:0]    schk_idx_reg;
    logic              srd_pend_reg;
    logic [SCW-1:0]    cnt_reg;
    logic [SAW-1:0]    sbase_reg;
    logic [ADDR_W-1:0] delta_reg;
    logic [ADDR_W-1:0] bd_reg;

    // Result and output registers
    logic [STAT_W-1:0] res_status_reg;
    logic [ADDR_W-1:0] res_phys_reg;
    logic              m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    // RAM ports
    logic              ent_we;
    logic [EW-1:0]     ent_wdata;
    logic [EW-1:0]     ent_rdata;
    logic              str_we;
    logic [SAW-1:0]    str_waddr;
    logic [SAW-1:0]    str_raddr;
    logic [2*ADDR_W-1:0] str_wdata;
    logic [2*ADDR_W-1:0] str_rdata;

    // Stripe request decode
    logic           tbl_full;
    logic           keep_stripe;
    logic [SCW-1:0] new_cnt;
    logic           commit;
    logic           is_stripe;

    assign is_stripe   = cmd.acc && (in_req == REQ_STRIPE);
    assign tbl_full    = (entry_count_reg >= CNTW'(MAX_CHUNKS));
    assign keep_stripe = !tbl_full && (staged_stripes_reg < SCW'(MAX_STRIPES));
    assign new_cnt     = staged_stripes_reg + SCW'(keep_stripe);
    assign commit      = is_stripe && s_tlast && !tbl_full &&
                         (staged_size_reg != '0) && (new_cnt != '0);

    assign str_we    = is_stripe && keep_stripe;
    assign str_waddr = SAW'(entry_count_reg[CW-1:0]) * SAW'(MAX_STRIPES) +
                       SAW'(staged_stripes_reg);
    assign str_wdata = {in_off, in_dev};
    assign ent_we    = commit;
    assign ent_wdata = {new_cnt, staged_striped_reg, staged_size_reg, staged_start_reg};
    assign str_raddr = sbase_reg + SAW'(sidx_reg);

    cat_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_CHUNKS)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (entry_count_reg[CW-1:0]),
        .wdata (ent_wdata),
        .raddr (scan_idx_reg[CW-1:0]),
        .rdata (ent_rdata)
    );

    cat_ram #(
        .WIDTH (2 * ADDR_W),
        .DEPTH (SD)
    ) u_stripe_ram (
        .aclk  (aclk),
        .we    (str_we),
        .waddr (str_waddr),
        .wdata (str_wdata),
        .raddr (str_raddr),
        .rdata (str_rdata)
    );

    // Chunk compare on the entry read back from the table
    logic [ADDR_W-1:0] ent_start;
    logic [ADDR_W-1:0] ent_size;
    logic              ent_striped;
    logic [SCW-1:0]    ent_cnt;
    logic [ADDR_W-1:0] delta;
    logic              ent_hit;
    logic              ent_last_miss;
    logic              scan_issue;

    assign ent_start   = ent_rdata[ADDR_W-1:0];
    assign ent_size    = ent_rdata[2*ADDR_W-1:ADDR_W];
    assign ent_striped = ent_rdata[2*ADDR_W];
    assign ent_cnt     = ent_rdata[EW-1:2*ADDR_W+1];
    assign delta       = addr_reg - ent_start;
    assign ent_hit     = rd_pend_reg && (addr_reg >= ent_start) && (delta < ent_size);
    assign ent_last_miss = rd_pend_reg && !ent_hit &&
                           ((CNTW'(chk_idx_reg) + CNTW'(1)) == entry_count_reg);
    assign scan_issue  = cmd.scan && (scan_idx_reg < entry_count_reg);

    // Stripe compare on the pair read back from the store
    logic [ADDR_W-1:0] st_dev;
    logic [ADDR_W-1:0] st_off;
    logic              str_hit;
    logic              str_last_miss;
    logic              strp_issue;

    assign st_dev        = str_rdata[ADDR_W-1:0];
    assign st_off        = str_rdata[2*ADDR_W-1:ADDR_W];
    assign str_hit       = srd_pend_reg && ((device_id == '0) || (st_dev == device_id));
    assign str_last_miss = srd_pend_reg && !str_hit &&
                           ((schk_idx_reg + SCW'(1)) == cnt_reg);
    assign strp_issue    = cmd.strp && (sidx_reg < cnt_reg);

    // Status to controller
    always_comb begin
        stat.is_lookup     = (in_req == REQ_LOOKUP);
        stat.tbl_empty     = (entry_count_reg == '0);
        stat.ent_go_stripe = ent_hit && !ent_striped && (ent_cnt != '0);
        stat.ent_done      = ent_last_miss || (ent_hit && (ent_striped || (ent_cnt == '0)));
        stat.str_done      = str_hit || str_last_miss;
        stat.out_free      = !m_valid_reg || m_tready;
    end

    // Table and staging updates on accepted requests
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg    <= '0;
            staged_start_reg   <= '0;
            staged_size_reg    <= '0;
            staged_striped_reg <= 1'b0;
            staged_stripes_reg <= '0;
        end else if (cmd.acc) begin
            unique case (in_req)
                REQ_CLEAR: begin
                    entry_count_reg    <= '0;
                    staged_start_reg   <= '0;
                    staged_size_reg    <= '0;
                    staged_striped_reg <= 1'b0;
                    staged_stripes_reg <= '0;
                end
                REQ_HEADER: begin
                    staged_start_reg   <= in_logical;
                    staged_size_reg    <= in_length;
                    staged_striped_reg <= ((in_flags & STRIPED_MASK) != '0);
                    staged_stripes_reg <= '0;
                end
                REQ_STRIPE: begin
                    if (commit) begin
                        entry_count_reg <= entry_count_reg + CNTW'(1);
                    end
                    if (s_tlast) begin
                        staged_start_reg   <= '0;
                        staged_size_reg    <= '0;
                        staged_striped_reg <= 1'b0;
                        staged_stripes_reg <= '0;
                    end else begin
                        staged_stripes_reg <= new_cnt;
                    end
                end
                REQ_LOOKUP: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Scan control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg  <= 1'b0;
            srd_pend_reg <= 1'b0;
            scan_idx_reg <= '0;
            sidx_reg     <= '0;
        end else begin
            if (cmd.acc) begin
                scan_idx_reg <= '0;
                rd_pend_reg  <= 1'b0;
            end else begin
                rd_pend_reg <= scan_issue;
                if (scan_issue) begin
                    scan_idx_reg <= scan_idx_reg + CNTW'(1);
                end
            end
            if (stat.ent_go_stripe && cmd.scan) begin
                sidx_reg     <= '0;
                srd_pend_reg <= 1'b0;
            end else begin
                srd_pend_reg <= strp_issue;
                if (strp_issue) begin
                    sidx_reg <= sidx_reg + SCW'(1);
                end
            end
        end
    end

    // Scan payload registers
    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            addr_reg <= in_logical;
        end
        if (scan_issue) begin
            chk_idx_reg <= scan_idx_reg[CW-1:0];
        end
        if (strp_issue) begin
            schk_idx_reg <= sidx_reg;
        end
        if (cmd.scan && stat.ent_go_stripe) begin
            cnt_reg   <= ent_cnt;
            sbase_reg <= SAW'(chk_idx_reg) * SAW'(MAX_STRIPES);
            delta_reg <= delta;
        end
        // base plus in-chunk offset, ready before the first stripe returns
        bd_reg <= image_base + delta_reg;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.acc && (!stat.is_lookup || stat.tbl_empty)) begin
            res_phys_reg <= '0;
            unique case (in_req)
                REQ_STRIPE: begin
                    if (tbl_full) begin
                        res_status_reg <= STAT_TABLE_FULL;
                    end else if (!keep_stripe) begin
                        res_status_reg <= STAT_TOO_MANY;
                    end else begin
                        res_status_reg <= STAT_OK;
                    end
                end
                REQ_LOOKUP: res_status_reg <= STAT_NO_CHUNK;
                default:    res_status_reg <= STAT_OK;
            endcase
        end else if (cmd.scan && stat.ent_done) begin
            res_phys_reg <= '0;
            priority if (!ent_hit) begin
                res_status_reg <= STAT_NO_CHUNK;
            end else if (ent_striped) begin
                res_status_reg <= STAT_STRIPED;
            end else begin
                res_status_reg <= STAT_NO_DEV;
            end
        end else if (cmd.strp && stat.str_done) begin
            if (str_hit) begin
                res_status_reg <= STAT_OK;
                res_phys_reg   <= bd_reg + st_off;
            end else begin
                res_status_reg <= STAT_NO_DEV;
                res_phys_reg   <= '0;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= OUT_DATA_W'({res_phys_reg, res_status_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### src/chunk_address_translator.sv
// Top level of the chunk address translator: configuration registers,
// controller and datapath. Depends on cat_pkg, cat_ctrl, cat_datapath.
//
// Requests come in one at a time on the s_ stream and each gives exactly
// one result on the m_ stream. Clear, header and stripe requests need no
// table scan. A lookup scans the chunk table and, when the covering
// chunk's stripe list is to be searched, then that list: each is read one
// entry per cycle through a single registered RAM read port each. A
// finished result waits in the output register while the next request
// is transferred. The tables need no clearing pass after reset; a clear
// request takes effect at once.
module chunk_address_translator #(
    parameter int MAX_CHUNKS  = cat_pkg::MAX_CHUNKS_DEF,
    parameter int MAX_STRIPES = cat_pkg::MAX_STRIPES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: logical_addr, chunk_length, chunk_flags, stripe_device,
    //          stripe_offset (from bit 0 up)
    input  logic [cat_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: req_type
    input  logic [cat_pkg::REQ_W-1:0]       s_tuser,
    // s_tlast: last_stripe
    input  logic                            s_tlast,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: status, physical_addr, zero pad (from bit 0 up)
    output logic [cat_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cat_pkg::PADDR_W-1:0]     paddr,
    input  logic [cat_pkg::CFG_W-1:0]       pwdata,
    output logic [cat_pkg::CFG_W-1:0]       prdata,
    output logic                            pready
);
    import cat_pkg::*;

    logic [CFG_W-1:0] image_base_reg;
    logic [CFG_W-1:0] device_id_reg;
    logic             cfg_wr;
    logic             cfg_sel;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Register write and read; bit 3 of the address picks the register
    assign pready  = 1'b1;
    assign cfg_sel = paddr[3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_base_reg <= '0;
            device_id_reg  <= '0;
        end else if (cfg_wr) begin
            if (cfg_sel == 1'(REG_DEVICE_ID)) begin
                device_id_reg <= pwdata;
            end else begin
                image_base_reg <= pwdata;
            end
        end
    end

    assign prdata = (cfg_sel == 1'(REG_IMAGE_BASE)) ? image_base_reg : device_id_reg;

    cat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cat_datapath #(
        .MAX_CHUNKS  (MAX_CHUNKS),
        .MAX_STRIPES (MAX_STRIPES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .image_base (image_base_reg),
        .device_id  (device_id_reg),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

    // A result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending result");

    // One request at a time: a transfer is never followed by another at once
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while one is still in work");

    // Status codes stay in their defined range
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[STAT_W-1:0] <= STAT_TOO_MANY))
        else $error("undefined status code");

    // A result with a status other than OK carries a zero address
    a_phys_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[STAT_W-1:0] != STAT_OK)) |->
        (m_tdata[STAT_W+ADDR_W-1:STAT_W] == '0))
        else $error("nonzero address with failing status");

endmodule
